// ===== rtl/core/cbt_pkg.sv =====
package cbt_pkg;

   localparam int unsigned WORD_BITS_DEF  = 32;
   localparam int unsigned MAX_CHUNKS_DEF = 4096;

   localparam int unsigned ACTION_W       = 2;
   localparam int unsigned CHUNK_ID_W     = 12;
   localparam int unsigned WORD_INDEX_W   = 7;
   localparam int unsigned WORD_DATA_W    = 32;
   localparam int unsigned CHUNK_ID_OUT_W = 13;
   localparam int unsigned SIZE_W         = 16;
   localparam int unsigned WORD_OUT_W     = 32;

   localparam int unsigned COUNT_W = 13;
   localparam int unsigned BYTES_W = 16;
   localparam int unsigned PADDR_W = 4;
   localparam int unsigned PDATA_W = 32;

   localparam logic [COUNT_W-1:0] CHUNK_COUNT_RST      = COUNT_W'(1);
   localparam logic [BYTES_W-1:0] CHUNK_BYTES_RST      = BYTES_W'(512);
   localparam logic [BYTES_W-1:0] LAST_CHUNK_BYTES_RST = BYTES_W'(512);

   typedef enum logic [ACTION_W-1:0] {
      ACT_MARK = 2'd0,
      ACT_NEXT = 2'd1,
      ACT_LOAD = 2'd2,
      ACT_READ = 2'd3
   } action_type;

   typedef enum logic [1:0] {
      REG_CHUNK_COUNT      = 2'd0,
      REG_CHUNK_BYTES      = 2'd1,
      REG_LAST_CHUNK_BYTES = 2'd2
   } reg_index_type;

   typedef enum logic [3:0] {
      ST_CLEAR,
      ST_IDLE,
      ST_SPLIT_Q,
      ST_SPLIT_R,
      ST_RMW_RD,
      ST_RMW_WR,
      ST_LOAD_WR,
      ST_WORD_RD,
      ST_WORD_CAP,
      ST_SCAN_RD,
      ST_SCAN_CHK,
      ST_FM_ONES,
      ST_FM_POS,
      ST_DONE
   } state_type;

   typedef struct packed {
      logic latch;
      logic clr_wr;
      logic split_q;
      logic split_r;
      logic rmw_rd;
      logic rmw_wr;
      logic load_wr;
      logic word_rd;
      logic word_cap;
      logic scan_rd;
      logic scan_inc;
      logic fm_ones;
      logic fm_pos;
      logic out_load;
   } cmd_type;

   typedef struct packed {
      action_type req_action;
      logic       req_ok;
      action_type action;
      logic       ok;
      logic       scan_end;
      logic       scan_full;
      logic       clr_last;
      logic       rsp_free;
   } stat_type;

endpackage

// ===== rtl/core/cbt_csr.sv =====
module cbt_csr
   import cbt_pkg::*;
#(
   parameter int unsigned WORD_BITS  = WORD_BITS_DEF,
   parameter int unsigned MAX_CHUNKS = MAX_CHUNKS_DEF,
   localparam int unsigned CNT_W     = $clog2(MAX_CHUNKS + 1),
   localparam int unsigned MAP_WORDS = (MAX_CHUNKS + WORD_BITS - 1) / WORD_BITS,
   localparam int unsigned SCAN_W    = $clog2(MAP_WORDS + 1)
) (
   input  logic                 clock,
   input  logic                 reset,
   input  logic                 psel,
   input  logic                 penable,
   input  logic                 pwrite,
   input  logic [PADDR_W-1:0]   paddr,
   input  logic [PDATA_W-1:0]   pwdata,
   output logic [PDATA_W-1:0]   prdata,
   output logic                 pready,
   output logic [CNT_W-1:0]     cnt,
   output logic [SCAN_W-1:0]    used,
   output logic [WORD_BITS-1:0] last_mask,
   output logic [BYTES_W-1:0]   chunk_bytes,
   output logic [BYTES_W-1:0]   last_chunk_bytes
);

   localparam int unsigned N1     = CNT_W + 1;
   localparam int unsigned L1     = $clog2(WORD_BITS);
   localparam int unsigned S1     = N1 + L1;
   localparam int unsigned M1     = ((1 << S1) + WORD_BITS - 1) / WORD_BITS;
   localparam int unsigned PROD_W = 2 * N1 + 2;

   logic [COUNT_W-1:0]   chunk_count_ff;
   logic [BYTES_W-1:0]   chunk_bytes_ff;
   logic [BYTES_W-1:0]   last_bytes_ff;
   logic [SCAN_W-1:0]    used_ff, used_in;
   logic [WORD_BITS-1:0] mask_ff, mask_in;
   logic                 wr_en;
   logic [N1-1:0]        round_up;
   logic [PROD_W-1:0]    prod;
   int unsigned          rem;

   assign pready = 1'b1;
   assign wr_en  = psel & penable & pwrite;

   always_ff @(posedge clock) begin
      if (reset) begin
         chunk_count_ff <= CHUNK_COUNT_RST;
         chunk_bytes_ff <= CHUNK_BYTES_RST;
         last_bytes_ff  <= LAST_CHUNK_BYTES_RST;
         used_ff        <= SCAN_W'(1);
         mask_ff        <= WORD_BITS'(1);
      end else begin
         used_ff <= used_in;
         mask_ff <= mask_in;
         if (wr_en) begin
            case (paddr[3:2])
               REG_CHUNK_COUNT:      chunk_count_ff <= pwdata[COUNT_W-1:0];
               REG_CHUNK_BYTES:      chunk_bytes_ff <= pwdata[BYTES_W-1:0];
               REG_LAST_CHUNK_BYTES: last_bytes_ff  <= pwdata[BYTES_W-1:0];
               default: ;
            endcase
         end
      end
   end

   always_comb begin
      case (paddr[3:2])
         REG_CHUNK_COUNT:      prdata = PDATA_W'(chunk_count_ff);
         REG_CHUNK_BYTES:      prdata = PDATA_W'(chunk_bytes_ff);
         REG_LAST_CHUNK_BYTES: prdata = PDATA_W'(last_bytes_ff);
         default:              prdata = '0;
      endcase
   end

   // count clamped to 1..MAX_CHUNKS
   always_comb begin
      if (chunk_count_ff == '0) begin
         cnt = CNT_W'(1);
      end else if (32'(chunk_count_ff) > MAX_CHUNKS) begin
         cnt = CNT_W'(MAX_CHUNKS);
      end else begin
         cnt = CNT_W'(chunk_count_ff);
      end
   end

   // words in use: ceil(cnt / WORD_BITS) by reciprocal multiply
   always_comb begin
      round_up = N1'(cnt) + N1'(WORD_BITS - 1);
      prod     = PROD_W'(round_up) * PROD_W'(M1);
      used_in  = SCAN_W'(prod >> S1);
   end

   always_comb begin
      rem     = 32'(cnt) - (32'(used_ff) - 32'd1) * WORD_BITS;
      mask_in = {WORD_BITS{1'b1}} >> (WORD_BITS - rem);
   end

   assign used             = used_ff;
   assign last_mask        = mask_ff;
   assign chunk_bytes      = chunk_bytes_ff;
   assign last_chunk_bytes = last_bytes_ff;

endmodule

// ===== rtl/core/cbt_ctrl.sv =====
module cbt_ctrl
   import cbt_pkg::*;
(
   input  logic     clock,
   input  logic     reset,
   input  logic     req_valid,
   output logic     req_stall,
   input  stat_type stat,
   output cmd_type  cmd
);

   state_type state_ff, state_in;
   logic      need_fm;

   assign need_fm = (stat.action == ACT_NEXT) || ((stat.action == ACT_LOAD) && stat.ok);

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_CLEAR;
      end else begin
         state_ff <= state_in;
      end
   end

   always_comb begin
      state_in = state_ff;
      case (state_ff)
         ST_CLEAR: begin
            if (stat.clr_last) state_in = ST_IDLE;
         end
         ST_IDLE: begin
            if (req_valid) begin
               if (!stat.req_ok) begin
                  state_in = ST_SCAN_RD;
               end else begin
                  case (stat.req_action)
                     ACT_MARK: state_in = ST_SPLIT_Q;
                     ACT_NEXT: state_in = ST_SPLIT_Q;
                     ACT_LOAD: state_in = ST_LOAD_WR;
                     ACT_READ: state_in = ST_WORD_RD;
                     default:  state_in = ST_SCAN_RD;
                  endcase
               end
            end
         end
         ST_SPLIT_Q:  state_in = ST_SPLIT_R;
         ST_SPLIT_R:  state_in = ST_RMW_RD;
         ST_RMW_RD:   state_in = ST_RMW_WR;
         ST_RMW_WR:   state_in = ST_SCAN_RD;
         ST_LOAD_WR:  state_in = ST_SCAN_RD;
         ST_WORD_RD:  state_in = ST_WORD_CAP;
         ST_WORD_CAP: state_in = ST_SCAN_RD;
         ST_SCAN_RD: begin
            if (stat.scan_end) begin
               state_in = need_fm ? ST_FM_ONES : ST_DONE;
            end else begin
               state_in = ST_SCAN_CHK;
            end
         end
         ST_SCAN_CHK: begin
            if (stat.scan_full) begin
               state_in = ST_SCAN_RD;
            end else begin
               state_in = need_fm ? ST_FM_ONES : ST_DONE;
            end
         end
         ST_FM_ONES: state_in = ST_FM_POS;
         ST_FM_POS:  state_in = ST_DONE;
         ST_DONE: begin
            if (stat.rsp_free) state_in = ST_IDLE;
         end
         default: state_in = ST_CLEAR;
      endcase
   end

   always_comb begin
      cmd       = '0;
      req_stall = (state_ff != ST_IDLE);
      case (state_ff)
         ST_CLEAR:    cmd.clr_wr   = 1'b1;
         ST_IDLE:     cmd.latch    = req_valid;
         ST_SPLIT_Q:  cmd.split_q  = 1'b1;
         ST_SPLIT_R:  cmd.split_r  = 1'b1;
         ST_RMW_RD:   cmd.rmw_rd   = 1'b1;
         ST_RMW_WR:   cmd.rmw_wr   = 1'b1;
         ST_LOAD_WR:  cmd.load_wr  = 1'b1;
         ST_WORD_RD:  cmd.word_rd  = 1'b1;
         ST_WORD_CAP: cmd.word_cap = 1'b1;
         ST_SCAN_RD:  cmd.scan_rd  = !stat.scan_end;
         ST_SCAN_CHK: cmd.scan_inc = stat.scan_full;
         ST_FM_ONES:  cmd.fm_ones  = 1'b1;
         ST_FM_POS:   cmd.fm_pos   = 1'b1;
         ST_DONE:     cmd.out_load = stat.rsp_free;
         default: ;
      endcase
   end

endmodule

// ===== rtl/core/cbt_dpath.sv =====
module cbt_dpath
   import cbt_pkg::*;
#(
   parameter int unsigned WORD_BITS  = WORD_BITS_DEF,
   parameter int unsigned MAX_CHUNKS = MAX_CHUNKS_DEF,
   localparam int unsigned CNT_W     = $clog2(MAX_CHUNKS + 1),
   localparam int unsigned MAP_WORDS = (MAX_CHUNKS + WORD_BITS - 1) / WORD_BITS,
   localparam int unsigned SCAN_W    = $clog2(MAP_WORDS + 1)
) (
   input  logic                      clock,
   input  logic                      reset,
   input  cmd_type                   cmd,
   output stat_type                  stat,
   input  logic [ACTION_W-1:0]       req_action,
   input  logic [CHUNK_ID_W-1:0]     req_chunk_id,
   input  logic [WORD_INDEX_W-1:0]   req_word_index,
   input  logic [WORD_DATA_W-1:0]    req_word_data,
   input  logic                      rsp_stall,
   output logic                      rsp_valid,
   output logic [CHUNK_ID_OUT_W-1:0] rsp_chunk_id_out,
   output logic [SIZE_W-1:0]         rsp_size,
   output logic [WORD_OUT_W-1:0]     rsp_word_out,
   output logic                      rsp_all_done,
   output logic                      rsp_status,
   input  logic [CNT_W-1:0]          cnt,
   input  logic [SCAN_W-1:0]         used,
   input  logic [WORD_BITS-1:0]      last_mask,
   input  logic [BYTES_W-1:0]        chunk_bytes,
   input  logic [BYTES_W-1:0]        last_chunk_bytes
);

   localparam int unsigned ADDR_W = (MAP_WORDS > 1) ? $clog2(MAP_WORDS) : 1;
   localparam int unsigned BIT_W  = $clog2(WORD_BITS);
   localparam int unsigned S      = CNT_W + BIT_W;
   localparam int unsigned M      = ((1 << S) + WORD_BITS - 1) / WORD_BITS;
   localparam int unsigned PROD_W = 2 * CNT_W + 2;

   logic [WORD_BITS-1:0] mem [MAP_WORDS];

   action_type                act_req;
   action_type                action_ff;
   logic                      ok_ff;
   logic                      req_ok;
   logic [CNT_W-1:0]          x_ff;
   logic [ADDR_W-1:0]         widx_ff;
   logic [WORD_BITS-1:0]      data_ff;
   logic [SIZE_W-1:0]         size_ff;
   logic [CHUNK_ID_OUT_W-1:0] id_out_ff;
   logic [WORD_OUT_W-1:0]     word_ff;
   logic [ADDR_W-1:0]         q_ff;
   logic [BIT_W-1:0]          r_ff;
   logic [WORD_BITS-1:0]      rdata_ff;
   logic [BIT_W-1:0]          ones_ff, ones;
   logic [SCAN_W-1:0]         scan_ff, scan_in;
   logic [CNT_W-1:0]          next_read_ff, next_read_in;
   logic [ADDR_W-1:0]         clr_ff, clr_in;
   logic                      rsp_valid_ff, rsp_valid_in;
   logic [CHUNK_ID_OUT_W-1:0] rsp_id_ff;
   logic [SIZE_W-1:0]         rsp_size_ff;
   logic [WORD_OUT_W-1:0]     rsp_word_ff;
   logic                      rsp_done_ff;
   logic                      rsp_status_ff;

   logic [PROD_W-1:0]    prod;
   logic                 scan_end;
   logic                 all_done;
   logic [31:0]          sel_id;
   logic [SIZE_W-1:0]    size_sel;
   logic                 wr_en, rd_en;
   logic [ADDR_W-1:0]    wr_addr, rd_addr;
   logic [WORD_BITS-1:0] wr_data;
   logic [WORD_BITS:0]   lowz;
   logic [31:0]          pos;

   assign act_req = action_type'(req_action);

   always_comb begin
      case (act_req)
         ACT_MARK: req_ok = 32'(req_chunk_id) < 32'(cnt);
         ACT_NEXT: req_ok = 32'(next_read_ff) < 32'(cnt);
         default:  req_ok = 32'(req_word_index) < MAP_WORDS;
      endcase
      sel_id   = (act_req == ACT_NEXT) ? 32'(next_read_ff) : 32'(req_chunk_id);
      size_sel = (sel_id + 32'd1 == 32'(cnt)) ? last_chunk_bytes : chunk_bytes;
   end

   assign scan_end = 32'(scan_ff) >= 32'(used);
   assign all_done = scan_end ||
                     ((32'(scan_ff) + 32'd1 == 32'(used)) &&
                      ((rdata_ff & last_mask) == last_mask));

   assign stat.req_action = act_req;
   assign stat.req_ok     = req_ok;
   assign stat.action     = action_ff;
   assign stat.ok         = ok_ff;
   assign stat.scan_end   = scan_end;
   assign stat.scan_full  = (rdata_ff == {WORD_BITS{1'b1}});
   assign stat.clr_last   = (clr_ff == ADDR_W'(MAP_WORDS - 1));
   assign stat.rsp_free   = !rsp_valid_ff || !rsp_stall;

   // split the chunk number into word and bit by reciprocal multiply
   assign prod = PROD_W'(x_ff) * PROD_W'(M);

   // lowest clear bit of the scan word
   always_comb begin
      lowz = ~{1'b0, rdata_ff} & ({1'b0, rdata_ff} + (WORD_BITS + 1)'(1));
      ones = '0;
      for (int i = 0; i < WORD_BITS; i++) begin
         if (lowz[i]) ones = ones | BIT_W'(i);
      end
   end

   always_comb begin
      pos = 32'(scan_ff) * WORD_BITS + 32'(ones_ff);
      if (scan_end || (pos > 32'(cnt))) begin
         next_read_in = cnt;
      end else begin
         next_read_in = CNT_W'(pos);
      end
      if (!cmd.fm_pos) next_read_in = next_read_ff;
   end

   always_comb begin
      scan_in = scan_ff;
      if (cmd.load_wr) begin
         scan_in = '0;
      end else if (cmd.scan_inc) begin
         scan_in = scan_ff + SCAN_W'(1);
      end
      clr_in = cmd.clr_wr ? clr_ff + ADDR_W'(1) : clr_ff;
      if (cmd.out_load) begin
         rsp_valid_in = 1'b1;
      end else if (!rsp_stall) begin
         rsp_valid_in = 1'b0;
      end else begin
         rsp_valid_in = rsp_valid_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         scan_ff      <= '0;
         next_read_ff <= '0;
         clr_ff       <= '0;
         rsp_valid_ff <= 1'b0;
         action_ff    <= ACT_MARK;
         ok_ff        <= 1'b0;
      end else begin
         scan_ff      <= scan_in;
         next_read_ff <= next_read_in;
         clr_ff       <= clr_in;
         rsp_valid_ff <= rsp_valid_in;
         if (cmd.latch) begin
            action_ff <= act_req;
            ok_ff     <= req_ok;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (cmd.latch) begin
         x_ff    <= (act_req == ACT_NEXT) ? next_read_ff : CNT_W'(req_chunk_id);
         widx_ff <= ADDR_W'(req_word_index);
         data_ff <= WORD_BITS'(req_word_data);
         word_ff <= '0;
         size_ff <= (req_ok && ((act_req == ACT_MARK) || (act_req == ACT_NEXT))) ?
                    size_sel : '0;
         id_out_ff <= (act_req == ACT_NEXT) ? CHUNK_ID_OUT_W'(next_read_ff) : '0;
      end
      if (cmd.split_q)  q_ff    <= ADDR_W'(prod >> S);
      if (cmd.split_r)  r_ff    <= BIT_W'(32'(x_ff) - 32'(q_ff) * WORD_BITS);
      if (cmd.word_cap) word_ff <= WORD_OUT_W'(rdata_ff);
      if (cmd.fm_ones)  ones_ff <= ones;
      if (cmd.out_load) begin
         rsp_id_ff     <= id_out_ff;
         rsp_size_ff   <= size_ff;
         rsp_word_ff   <= word_ff;
         rsp_done_ff   <= all_done;
         rsp_status_ff <= !ok_ff;
      end
   end

   always_comb begin
      wr_en   = cmd.clr_wr | cmd.rmw_wr | cmd.load_wr;
      wr_addr = q_ff;
      wr_data = rdata_ff | (WORD_BITS'(1) << r_ff);
      if (cmd.clr_wr) begin
         wr_addr = clr_ff;
         wr_data = '0;
      end else if (cmd.load_wr) begin
         wr_addr = widx_ff;
         wr_data = data_ff;
      end
      rd_en   = cmd.rmw_rd | cmd.word_rd | cmd.scan_rd;
      rd_addr = q_ff;
      if (cmd.word_rd) begin
         rd_addr = widx_ff;
      end else if (cmd.scan_rd) begin
         rd_addr = ADDR_W'(scan_ff);
      end
   end

   always_ff @(posedge clock) begin
      if (wr_en) mem[wr_addr] <= wr_data;
      if (rd_en) rdata_ff <= mem[rd_addr];
   end

   assign rsp_valid        = rsp_valid_ff;
   assign rsp_chunk_id_out = rsp_id_ff;
   assign rsp_size         = rsp_size_ff;
   assign rsp_word_out     = rsp_word_ff;
   assign rsp_all_done     = rsp_done_ff;
   assign rsp_status       = rsp_status_ff;

endmodule

// ===== rtl/core/chunk_bitmap_tracker.sv =====
// Chunk bitmap tracker: one bit per transfer chunk in a single bitmap RAM of
// ceil(MAX_CHUNKS/WORD_BITS) words. After reset a clearing pass writes every
// word to zero, one per cycle, and no request is taken until it ends; register
// writes are taken throughout. The tracker takes one request at a time: a mark
// or next does a read-modify-write of its bit, a load writes a word and a read
// reads one, and each then scans on past every full word of the bitmap. The
// pace is set by the one read port of the RAM with its registered output, which
// the read-modify-write and the scan share. A finished response sits in an
// output register, so the next request is taken while it waits.
module chunk_bitmap_tracker
   import cbt_pkg::*;
#(
   parameter int unsigned WORD_BITS  = WORD_BITS_DEF,
   parameter int unsigned MAX_CHUNKS = MAX_CHUNKS_DEF
) (
   input  logic                      clock,
   input  logic                      reset,
   input  logic                      req_valid,
   output logic                      req_stall,
   input  logic [ACTION_W-1:0]       req_action,
   input  logic [CHUNK_ID_W-1:0]     req_chunk_id,
   input  logic [WORD_INDEX_W-1:0]   req_word_index,
   input  logic [WORD_DATA_W-1:0]    req_word_data,
   output logic                      rsp_valid,
   input  logic                      rsp_stall,
   output logic [CHUNK_ID_OUT_W-1:0] rsp_chunk_id_out,
   output logic [SIZE_W-1:0]         rsp_size,
   output logic [WORD_OUT_W-1:0]     rsp_word_out,
   output logic                      rsp_all_done,
   output logic                      rsp_status,
   input  logic                      psel,
   input  logic                      penable,
   input  logic                      pwrite,
   input  logic [PADDR_W-1:0]        paddr,
   input  logic [PDATA_W-1:0]        pwdata,
   output logic [PDATA_W-1:0]        prdata,
   output logic                      pready
);

   localparam int unsigned CNT_W     = $clog2(MAX_CHUNKS + 1);
   localparam int unsigned MAP_WORDS = (MAX_CHUNKS + WORD_BITS - 1) / WORD_BITS;
   localparam int unsigned SCAN_W    = $clog2(MAP_WORDS + 1);

   cmd_type              cmd;
   stat_type             stat;
   logic [CNT_W-1:0]     cnt;
   logic [SCAN_W-1:0]    used;
   logic [WORD_BITS-1:0] last_mask;
   logic [BYTES_W-1:0]   chunk_bytes;
   logic [BYTES_W-1:0]   last_chunk_bytes;

   cbt_csr #(
      .WORD_BITS  (WORD_BITS),
      .MAX_CHUNKS (MAX_CHUNKS)
   ) u_csr (
      .clock            (clock),
      .reset            (reset),
      .psel             (psel),
      .penable          (penable),
      .pwrite           (pwrite),
      .paddr            (paddr),
      .pwdata           (pwdata),
      .prdata           (prdata),
      .pready           (pready),
      .cnt              (cnt),
      .used             (used),
      .last_mask        (last_mask),
      .chunk_bytes      (chunk_bytes),
      .last_chunk_bytes (last_chunk_bytes)
   );

   cbt_ctrl u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_stall (req_stall),
      .stat      (stat),
      .cmd       (cmd)
   );

   cbt_dpath #(
      .WORD_BITS  (WORD_BITS),
      .MAX_CHUNKS (MAX_CHUNKS)
   ) u_dpath (
      .clock            (clock),
      .reset            (reset),
      .cmd              (cmd),
      .stat             (stat),
      .req_action       (req_action),
      .req_chunk_id     (req_chunk_id),
      .req_word_index   (req_word_index),
      .req_word_data    (req_word_data),
      .rsp_stall        (rsp_stall),
      .rsp_valid        (rsp_valid),
      .rsp_chunk_id_out (rsp_chunk_id_out),
      .rsp_size         (rsp_size),
      .rsp_word_out     (rsp_word_out),
      .rsp_all_done     (rsp_all_done),
      .rsp_status       (rsp_status),
      .cnt              (cnt),
      .used             (used),
      .last_mask        (last_mask),
      .chunk_bytes      (chunk_bytes),
      .last_chunk_bytes (last_chunk_bytes)
   );

endmodule
